/* hdl/bthin_pkg.sv */
// Shared widths, register indexes and row window type for the thinning block.
`default_nettype none

package bthin_pkg;

  localparam int ROW_W      = 64;
  localparam int ROWNUM_W   = 6;
  localparam int ITER_W     = 12;
  localparam int WIDTH_W    = 7;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 12;
  localparam int OUT_TDATA_W = 88;
  localparam int OUT_PAD_W  = OUT_TDATA_W - ROW_W - ROWNUM_W - ITER_W;

  localparam logic [ITER_W-1:0] ITER_MAX = {ITER_W{1'b1}};

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ITER_LIMIT  = 1'b1;

  // three consecutive rows as they stood before the current sub-pass
  typedef struct packed {
    logic [ROW_W-1:0] prv;
    logic [ROW_W-1:0] cur;
    logic [ROW_W-1:0] nxt;
  } row_win_t;

endpackage

`default_nettype wire

/* hdl/bthin_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bthin_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/bthin_mark.sv */
// Zhang-Suen deletion test across one row, all columns in parallel.
`default_nettype none

module bthin_mark (
  input  wire bthin_pkg::row_win_t          win,
  input  wire logic                         second,
  output logic      [bthin_pkg::ROW_W-1:0]  mark
);

  import bthin_pkg::*;

  // one zero column on each side: edge neighbors read as background
  logic [ROW_W+1:0] pp;
  logic [ROW_W+1:0] cp;
  logic [ROW_W+1:0] np;

  assign pp = {1'b0, win.prv, 1'b0};
  assign cp = {1'b0, win.cur, 1'b0};
  assign np = {1'b0, win.nxt, 1'b0};

  always_comb begin
    logic [7:0] n;
    logic [3:0] sum;
    logic [3:0] trans;
    logic       keep;
    mark = '0;
    for (int j = 0; j < ROW_W; j++) begin
      // P2 P3 P4 P5 P6 P7 P8 P9, clockwise from north
      n[0] = pp[j+1];
      n[1] = pp[j+2];
      n[2] = cp[j+2];
      n[3] = np[j+2];
      n[4] = np[j+1];
      n[5] = np[j];
      n[6] = cp[j];
      n[7] = pp[j];
      sum   = '0;
      trans = '0;
      for (int k = 0; k < 8; k++) begin
        sum = sum + 4'(n[k]);
        if (!n[k] && n[3'(k + 1)]) begin
          trans = trans + 4'd1;
        end
      end
      if (!second) begin
        keep = (n[0] & n[2] & n[4]) | (n[2] & n[4] & n[6]);
      end else begin
        keep = (n[0] & n[2] & n[6]) | (n[0] & n[4] & n[6]);
      end
      mark[j] = cp[j+1] && (sum >= 4'd2) && (sum <= 4'd6) && (trans == 4'd1) && !keep;
    end
  end

endmodule

`default_nettype wire

/* hdl/binary_image_thinning.sv */
// Zhang-Suen thinning of a binary image held in a row RAM.
//
// Input stream: one image row per transfer, in_tdata = row pixels (bit j = column j),
// in_tlast on the final row. Rows load one per cycle. Rows past MAX_HEIGHT are
// dropped; the last row still starts thinning. The image width register in force
// at the last row masks columns at or beyond it.
// Thinning: each sub-pass streams the h loaded rows through a three-row window
// out of the RAM (one read port, one write port) and writes the cleared rows
// back. One iteration is two sub-passes, entered through the ITER state. It
// stops when a sub-pass clears nothing or the iteration limit is reached
// (limit 0 = no limit). in_tready is low meanwhile.
// Output stream: h transfers, top row first; a row is read only once the
// previous one has reached the output register. out_tlast marks the bottom row.
// A stalled result sits in the output register; the block returns to loading
// once the last row is in that register, so the next image can load while it
// waits.
// Reset (synchronous, rst_n low) empties the row count, drops a pending result,
// sets image width 64 and iteration limit 0. The configuration port is always ready.
`default_nettype none

module binary_image_thinning #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: [63:0] row_bits
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [bthin_pkg::ROW_W-1:0]       in_tdata,
  input  wire logic                              in_tlast,
  // out_tdata: [63:0] thinned_row, [69:64] row_number, [81:70] iterations_done,
  //            [87:82] zero
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [bthin_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                   out_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bthin_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [bthin_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import bthin_pkg::*;

  localparam int AW = $clog2(MAX_HEIGHT);
  localparam int CW = $clog2(MAX_HEIGHT + 1);
  localparam int SW = $clog2(MAX_HEIGHT + 2);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ITER,
    ST_PASS,
    ST_EMIT
  } state_t;

  state_t            state_r;
  logic [WIDTH_W-1:0] width_r;
  logic [ITER_W-1:0] limit_r;
  logic [CW-1:0]     rows_r;
  logic [CW-1:0]     h_r;
  logic [ROW_W-1:0]  mask_r;
  logic [ROW_W-1:0]  mask_nxt;
  logic [ITER_W-1:0] iter_r;
  logic              second_r;
  logic              any_r;

  // sweep pipeline: read issue, window shift, mark and write back
  logic [SW-1:0]     s_r;
  logic              b_vld_r;
  logic              b_zero_r;
  logic [SW-1:0]     b_idx_r;
  logic              c_vld_r;
  logic [AW-1:0]     c_idx_r;
  row_win_t          win_r;
  logic [ROW_W-1:0]  mark;

  // emission
  logic [CW-1:0]     e_r;
  logic [AW-1:0]     ep_r;
  logic              rd_pend_r;
  logic              out_vld_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [ROWNUM_W-1:0] out_num_r;
  logic              out_last_r;
  logic [ITER_W-1:0] out_iter_r;

  logic              in_acc;
  logic              store_row;
  logic              sweep_step;
  logic              sweep_done;
  logic              emit_issue;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [ROW_W-1:0]  ram_rdata;

  assign in_tready  = (state_r == ST_LOAD);
  assign cfg_ready  = 1'b1;
  assign in_acc     = in_tvalid && in_tready;
  assign store_row  = in_acc && (rows_r < CW'(MAX_HEIGHT));

  assign sweep_step = (state_r == ST_PASS) && (s_r <= SW'(h_r));
  assign sweep_done = (state_r == ST_PASS) && (s_r == SW'(h_r) + SW'(1)) &&
                      !b_vld_r && !c_vld_r;
  assign emit_issue = (state_r == ST_EMIT) && !rd_pend_r && (e_r < h_r) &&
                      (!out_vld_r || out_tready);

  assign ram_we    = store_row || c_vld_r;
  assign ram_waddr = c_vld_r ? c_idx_r : rows_r[AW-1:0];
  assign ram_wdata = c_vld_r ? (win_r.cur & ~mark) : in_tdata;
  assign ram_re    = (sweep_step && (s_r < SW'(h_r))) || emit_issue;
  assign ram_raddr = (state_r == ST_PASS) ? s_r[AW-1:0] : e_r[AW-1:0];

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      mask_nxt[j] = (WIDTH_W'(j) < width_r) && (j < MAX_WIDTH);
    end
  end

  bthin_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_HEIGHT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bthin_mark u_mark (
    .win    (win_r),
    .second (second_r),
    .mark   (mark)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      width_r   <= WIDTH_W'(64);
      limit_r   <= '0;
      rows_r    <= '0;
      h_r       <= '0;
      iter_r    <= '0;
      second_r  <= 1'b0;
      any_r     <= 1'b0;
      s_r       <= '0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      e_r       <= '0;
      rd_pend_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_addr)
          CFG_IMAGE_WIDTH: width_r <= cfg_data[WIDTH_W-1:0];
          CFG_ITER_LIMIT:  limit_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end

      // sweep pipeline stages run regardless of the state decode below
      b_vld_r  <= sweep_step;
      b_zero_r <= (s_r == SW'(h_r));
      b_idx_r  <= s_r;
      c_vld_r  <= b_vld_r && (b_idx_r != '0);
      c_idx_r  <= AW'(b_idx_r - SW'(1));
      if (b_vld_r) begin
        win_r.prv <= win_r.cur;
        win_r.cur <= win_r.nxt;
        win_r.nxt <= b_zero_r ? '0 : (ram_rdata & mask_r);
      end
      if (c_vld_r && (mark != '0)) begin
        any_r <= 1'b1;
      end

      unique case (state_r)
        ST_LOAD: begin
          if (in_acc && in_tlast) begin
            h_r     <= store_row ? rows_r + CW'(1) : rows_r;
            rows_r  <= '0;
            mask_r  <= mask_nxt;
            iter_r  <= '0;
            state_r <= ST_ITER;
          end else if (store_row) begin
            rows_r <= rows_r + CW'(1);
          end
        end

        ST_ITER: begin
          if ((limit_r != '0) && (iter_r >= limit_r)) begin
            e_r     <= '0;
            state_r <= ST_EMIT;
          end else begin
            if (iter_r != ITER_MAX) begin
              iter_r <= iter_r + ITER_W'(1);
            end
            second_r <= 1'b0;
            any_r    <= 1'b0;
            s_r      <= '0;
            win_r    <= '0;
            state_r  <= ST_PASS;
          end
        end

        ST_PASS: begin
          if (sweep_step) begin
            s_r <= s_r + SW'(1);
          end
          if (sweep_done) begin
            if (!any_r) begin
              e_r     <= '0;
              state_r <= ST_EMIT;
            end else if (!second_r) begin
              second_r <= 1'b1;
              any_r    <= 1'b0;
              s_r      <= '0;
              win_r    <= '0;
            end else begin
              state_r <= ST_ITER;
            end
          end
        end

        ST_EMIT: begin
          if (emit_issue) begin
            e_r       <= e_r + CW'(1);
            ep_r      <= e_r[AW-1:0];
            rd_pend_r <= 1'b1;
          end
          if (rd_pend_r) begin
            rd_pend_r  <= 1'b0;
            out_vld_r  <= 1'b1;
            out_row_r  <= ram_rdata & mask_r;
            out_num_r  <= ROWNUM_W'(ep_r);
            out_last_r <= (CW'(ep_r) == h_r - CW'(1));
            out_iter_r <= iter_r;
            if (CW'(ep_r) == h_r - CW'(1)) begin
              state_r <= ST_LOAD;
            end
          end
        end

        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {OUT_PAD_W'(0), out_iter_r, out_num_r, out_row_r};

  // write-back row never coincides with the row being fetched
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re && (state_r == ST_PASS)) |-> (ram_waddr != ram_raddr))
    else $error("row RAM read and write hit the same row during a sweep");

  // a fetched output row always finds the output register free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_vld_r)
    else $error("output register overwritten while holding a row");

  // write-back only happens inside a sweep
  a_wb_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    c_vld_r |-> (state_r == ST_PASS))
    else $error("row write-back outside a sub-pass");

  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rows_r <= CW'(MAX_HEIGHT)) && (h_r <= CW'(MAX_HEIGHT)))
    else $error("row count beyond store depth");

endmodule

`default_nettype wire
